// ===== src/itf14_pkg.sv =====
// ----------------------------------------------------------------------------
// itf14_pkg
// Shared types, constants and the digit pattern table of the ITF-14 element
// encoder.
// ----------------------------------------------------------------------------
package itf14_pkg;

  localparam int unsigned DigitW    = 4;
  localparam int unsigned WidthW    = 8;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned NumDigits = 13;
  localparam int unsigned PosW      = 4;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned JobQDepth = 2;

  localparam logic [DigitW-1:0] MaxDigit = DigitW'(9);
  localparam logic [PosW-1:0]   LastPos  = PosW'(NumDigits - 1);

  localparam logic [CfgIdxW-1:0] CFG_NARROW_BAR   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_NARROW_SPACE = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_WIDE_BAR     = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_WIDE_SPACE   = CfgIdxW'(3);

  typedef logic [4:0] pattern_t;

  typedef struct packed {
    logic               start;
    logic               pair;
    logic               stop;
    pattern_t           bar_pat;
    pattern_t           space_pat;
    logic [DigitW-1:0]  check;
  } job_t;

  typedef struct packed {
    logic [WidthW-1:0] thin_bar;
    logic [WidthW-1:0] thin_gap;
    logic [WidthW-1:0] thick_bar;
    logic [WidthW-1:0] thick_gap;
  } widths_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_PAIR,
    PH_STOP
  } phase_t;

  // bit 4 is the first element, 1 = wide
  function automatic pattern_t wide_pattern(input logic [DigitW-1:0] d);
    pattern_t p;
    unique case (d)
      4'd0:    p = 5'b00110;
      4'd1:    p = 5'b10001;
      4'd2:    p = 5'b01001;
      4'd3:    p = 5'b11000;
      4'd4:    p = 5'b00101;
      4'd5:    p = 5'b10100;
      4'd6:    p = 5'b01100;
      4'd7:    p = 5'b00011;
      4'd8:    p = 5'b10010;
      default: p = 5'b01010;
    endcase
    return p;
  endfunction

endpackage

// ===== src/itf14_if.sv =====
// ----------------------------------------------------------------------------
// itf14 channel interfaces
// Valid/ready channels for digits, bar and space elements and register writes.
// ----------------------------------------------------------------------------
interface itf14_in_if;
  logic                          valid;
  logic                          ready;
  logic [itf14_pkg::DigitW-1:0]  digit;
  modport source (output valid, output digit, input ready);
  modport sink   (input valid, input digit, output ready);
endinterface

interface itf14_out_if;
  logic                          valid;
  logic                          ready;
  logic                          is_bar;
  logic [itf14_pkg::WidthW-1:0]  element_width;
  logic [itf14_pkg::DigitW-1:0]  check_digit;
  logic                          last;
  modport source (output valid, output is_bar, output element_width,
                  output check_digit, output last, input ready);
  modport sink   (input valid, input is_bar, input element_width,
                  input check_digit, input last, output ready);
endinterface

interface itf14_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [itf14_pkg::CfgIdxW-1:0] index;
  logic [itf14_pkg::WidthW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/itf14_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// itf14_cfg_regs
// Element width registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module itf14_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  itf14_cfg_if.sink           cfg_ch,
  output itf14_pkg::widths_t  widths
);

  itf14_pkg::widths_t widths_r;

  assign cfg_ch.ready = 1'b1;
  assign widths       = widths_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widths_r.thin_bar  <= itf14_pkg::WidthW'(4);
      widths_r.thin_gap  <= itf14_pkg::WidthW'(5);
      widths_r.thick_bar <= itf14_pkg::WidthW'(11);
      widths_r.thick_gap <= itf14_pkg::WidthW'(12);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        itf14_pkg::CFG_NARROW_BAR:   widths_r.thin_bar  <= cfg_ch.data;
        itf14_pkg::CFG_NARROW_SPACE: widths_r.thin_gap  <= cfg_ch.data;
        itf14_pkg::CFG_WIDE_BAR:     widths_r.thick_bar <= cfg_ch.data;
        itf14_pkg::CFG_WIDE_SPACE:   widths_r.thick_gap <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/itf14_front.sv =====
// ----------------------------------------------------------------------------
// itf14_front
// Takes digits, tracks position, held digit and weighted sum, and pushes an
// element job for the first digit, each odd-position digit and the last one.
// ----------------------------------------------------------------------------
module itf14_front (
  input  logic             clk,
  input  logic             rst_n,
  itf14_in_if.sink         in_ch,
  output itf14_pkg::job_t  job,
  output logic             job_push,
  input  logic             job_full
);

  logic [itf14_pkg::PosW-1:0]   pos_r, pos_nxt, pos_eff;
  logic [itf14_pkg::DigitW-1:0] held_r, held_nxt;
  logic [itf14_pkg::DigitW-1:0] sum_r, sum_nxt, sum_new, chk, d_sat;
  logic [4:0]                   prod;
  logic [5:0]                   acc;
  logic                         accept, at_last;

  assign in_ch.ready = !job_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    d_sat   = (in_ch.digit > itf14_pkg::MaxDigit) ? itf14_pkg::MaxDigit : in_ch.digit;
    pos_eff = (pos_r > itf14_pkg::LastPos) ? '0 : pos_r;
    at_last = (pos_eff == itf14_pkg::LastPos);
    prod    = pos_eff[0] ? {1'b0, d_sat} : ({1'b0, d_sat} + {d_sat, 1'b0});
    acc     = {2'b00, sum_r} + {1'b0, prod};
    if (acc >= 6'd30)      sum_new = 4'(acc - 6'd30);
    else if (acc >= 6'd20) sum_new = 4'(acc - 6'd20);
    else if (acc >= 6'd10) sum_new = 4'(acc - 6'd10);
    else                   sum_new = acc[3:0];
    chk = (sum_new == 4'd0) ? 4'd0 : 4'd10 - sum_new;
  end

  always_comb begin
    job.start     = (pos_eff == '0);
    job.pair      = pos_eff[0] || at_last;
    job.stop      = at_last;
    job.bar_pat   = itf14_pkg::wide_pattern(at_last ? d_sat : held_r);
    job.space_pat = itf14_pkg::wide_pattern(at_last ? chk : d_sat);
    job.check     = chk;
    job_push      = accept && (job.start || job.pair);
  end

  always_comb begin
    pos_nxt  = pos_r;
    held_nxt = held_r;
    sum_nxt  = sum_r;
    if (accept) begin
      if (at_last) begin
        pos_nxt  = '0;
        held_nxt = '0;
        sum_nxt  = '0;
      end else begin
        pos_nxt = pos_eff + 4'd1;
        sum_nxt = sum_new;
        if (!pos_eff[0]) held_nxt = d_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      held_r <= '0;
      sum_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      held_r <= held_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

// ===== src/itf14_job_fifo.sv =====
// ----------------------------------------------------------------------------
// itf14_job_fifo
// Short job queue between the digit front end and the element sequencer.
// ----------------------------------------------------------------------------
module itf14_job_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  itf14_pkg::job_t  wr_job,
  input  logic             push,
  output logic             full,
  output itf14_pkg::job_t  rd_job,
  output logic             rd_valid,
  input  logic             pop
);

  localparam int unsigned PtrW = (itf14_pkg::JobQDepth > 1) ?
                                 $clog2(itf14_pkg::JobQDepth) : 1;
  localparam int unsigned CntW = $clog2(itf14_pkg::JobQDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(itf14_pkg::JobQDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(itf14_pkg::JobQDepth);

  itf14_pkg::job_t   mem [itf14_pkg::JobQDepth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   count_r;

  assign full     = (count_r == CntFull);
  assign rd_valid = (count_r != '0);
  assign rd_job   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrW'(1);
      if (push && !pop)      count_r <= count_r + CntW'(1);
      else if (pop && !push) count_r <= count_r - CntW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> rd_valid)
    else $error("job queue underflow");

endmodule

// ===== src/itf14_back.sv =====
// ----------------------------------------------------------------------------
// itf14_back
// Element sequencer: plays out start, pair and stop elements of each job,
// one per cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module itf14_back (
  input  logic                clk,
  input  logic                rst_n,
  input  itf14_pkg::job_t     q_job,
  input  logic                q_valid,
  output logic                q_pop,
  input  itf14_pkg::widths_t  widths,
  itf14_out_if.source         out_ch
);

  itf14_pkg::phase_t            phase_r, phase_nxt, phase_follow;
  logic [itf14_pkg::IdxW-1:0]   idx_r, idx_nxt;
  itf14_pkg::job_t              job_r, job_nxt;

  logic                         out_valid_r;
  logic                         out_bar_r, out_last_r;
  logic [itf14_pkg::WidthW-1:0] out_width_r;
  logic [itf14_pkg::DigitW-1:0] out_chk_r;

  logic                         adv, end_of_phase, load;
  logic                         e_bar, e_last, e_wide;
  logic [itf14_pkg::WidthW-1:0] e_width;
  logic [itf14_pkg::DigitW-1:0] e_chk;
  logic [2:0]                   sel;

  assign adv = (phase_r != itf14_pkg::PH_IDLE) && (!out_valid_r || out_ch.ready);

  // element generation
  always_comb begin
    e_bar        = !idx_r[0];
    e_last       = 1'b0;
    e_chk        = '0;
    e_wide       = 1'b0;
    end_of_phase = 1'b0;
    sel          = 3'd4 - idx_r[3:1];
    unique case (phase_r)
      itf14_pkg::PH_START: begin
        end_of_phase = (idx_r == 4'd3);
      end
      itf14_pkg::PH_PAIR: begin
        e_wide       = e_bar ? job_r.bar_pat[sel] : job_r.space_pat[sel];
        end_of_phase = (idx_r == 4'd9);
      end
      itf14_pkg::PH_STOP: begin
        e_wide       = (idx_r == 4'd0);
        end_of_phase = (idx_r == 4'd2);
        e_last       = end_of_phase;
        e_chk        = end_of_phase ? job_r.check : '0;
      end
      default: ;
    endcase
    if (e_bar) e_width = e_wide ? widths.thick_bar : widths.thin_bar;
    else       e_width = e_wide ? widths.thick_gap : widths.thin_gap;
  end

  // next state
  always_comb begin
    unique case (phase_r)
      itf14_pkg::PH_START: phase_follow = job_r.pair ? itf14_pkg::PH_PAIR
                                                     : itf14_pkg::PH_IDLE;
      itf14_pkg::PH_PAIR:  phase_follow = job_r.stop ? itf14_pkg::PH_STOP
                                                     : itf14_pkg::PH_IDLE;
      default:             phase_follow = itf14_pkg::PH_IDLE;
    endcase

    load = q_valid && ((phase_r == itf14_pkg::PH_IDLE) ||
           (adv && end_of_phase && (phase_follow == itf14_pkg::PH_IDLE)));

    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    job_nxt   = job_r;
    if (load) begin
      job_nxt = q_job;
      idx_nxt = '0;
      if (q_job.start)     phase_nxt = itf14_pkg::PH_START;
      else if (q_job.pair) phase_nxt = itf14_pkg::PH_PAIR;
      else                 phase_nxt = itf14_pkg::PH_STOP;
    end else if (adv) begin
      if (end_of_phase) begin
        phase_nxt = phase_follow;
        idx_nxt   = '0;
      end else begin
        idx_nxt = idx_r + 4'd1;
      end
    end
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= itf14_pkg::PH_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      if (adv)               out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (adv) begin
      out_bar_r   <= e_bar;
      out_width_r <= e_width;
      out_chk_r   <= e_chk;
      out_last_r  <= e_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.is_bar        = out_bar_r;
  assign out_ch.element_width = out_width_r;
  assign out_ch.check_digit   = out_chk_r;
  assign out_ch.last          = out_last_r;

  a_last_is_bar: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> out_bar_r)
    else $error("stop element is not a bar");

  a_chk_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_chk_r != '0)) |-> out_last_r)
    else $error("check digit outside final element");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == itf14_pkg::PH_START) |-> (idx_r <= 4'd3)) and
    ((phase_r == itf14_pkg::PH_STOP)  |-> (idx_r <= 4'd2)) and
    ((phase_r == itf14_pkg::PH_PAIR)  |-> (idx_r <= 4'd9)))
    else $error("element index out of phase range");

  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> ((phase_r == itf14_pkg::PH_IDLE) || adv))
    else $error("job loaded while sequencer stalled");

endmodule

// ===== src/itf14_bar_element_encoder_top.sv =====
// ----------------------------------------------------------------------------
// itf14_bar_element_encoder_top
// ITF-14 (interleaved 2 of 5) bar/space element encoder.
//
//   channel  dir  payload                                    accepted when
//   in_ch    in   digit[3:0]                                 valid && ready
//   out_ch   out  is_bar, element_width[7:0], check_digit,   valid && ready
//                 last
//   cfg_ch   in   index[7:0], data[7:0]                      valid && ready
//
// One element leaves per cycle from the sequencer while out_ch is not stalled;
// a digit yields 4 (first), 0 (even), 10 (odd) or 13 (final) elements, 77 per symbol.
// Digits are taken while the two-entry job queue has room.
// rst_n is synchronous, active low; widths return to 4/5/11/12.
// A stalled output holds its element; the sequencer waits behind it.
// ----------------------------------------------------------------------------
module itf14_bar_element_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  itf14_in_if.sink    in_ch,
  itf14_out_if.source out_ch,
  itf14_cfg_if.sink   cfg_ch
);

  itf14_pkg::job_t     f_job, q_job;
  itf14_pkg::widths_t  widths;
  logic                f_push, q_full, q_valid, q_pop;

  itf14_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .widths (widths)
  );

  itf14_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .job      (f_job),
    .job_push (f_push),
    .job_full (q_full)
  );

  itf14_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_job   (f_job),
    .push     (f_push),
    .full     (q_full),
    .rd_job   (q_job),
    .rd_valid (q_valid),
    .pop      (q_pop)
  );

  itf14_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_job   (q_job),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .widths  (widths),
    .out_ch  (out_ch)
  );

endmodule
